FILE: hw/rtl/blseq_pkg.sv
// ----------------------------------------------------------------------------
// blseq_pkg
// Shared types, codes and reset values for the bridge lift sequencer.
// ----------------------------------------------------------------------------
package blseq_pkg;

   // default widths of the internal position and time state
   localparam int POSITION_BITS_DEF = 10;
   localparam int TIME_BITS_DEF     = 32;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int SAMPLE_W   = 10;
   localparam int PRESSURE_W = 10;
   localparam int DIST_W     = 9;
   localparam int NOW_W      = 32;
   localparam int CODE_W     = 3;
   localparam int DRIVE_W    = 2;
   localparam int DUTY_W     = 8;
   localparam int EVENT_W    = 4;
   localparam int TIMEOUT_W  = 16;

   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // request kinds
   localparam logic [OP_W-1:0] OP_STEP  = 2'd0;
   localparam logic [OP_W-1:0] OP_ESTOP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_UP_POSITION   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DOWN_POSITION = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OBJECT_LIMIT  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESSURE_LIMIT = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MOVE_TIMEOUT  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_START_BAND    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_BAND     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_MOTOR_DUTY    = 4'd7;

   // reported state codes
   localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd0;
   localparam logic [CODE_W-1:0] CODE_LIFTING  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_LOWERING = 3'd2;
   localparam logic [CODE_W-1:0] CODE_UP       = 3'd3;
   localparam logic [CODE_W-1:0] CODE_DOWN     = 3'd4;
   localparam logic [CODE_W-1:0] CODE_ERROR    = 3'd5;

   // motor direction
   localparam logic [DRIVE_W-1:0] DRIVE_STOP  = 2'd0;
   localparam logic [DRIVE_W-1:0] DRIVE_RAISE = 2'd1;
   localparam logic [DRIVE_W-1:0] DRIVE_LOWER = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_LIFTING  = 6'b000010,
      ST_LOWERING = 6'b000100,
      ST_UP       = 6'b001000,
      ST_DOWN     = 6'b010000,
      ST_ERROR    = 6'b100000
   } state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE        = 4'd0,
      EV_OBJECT_STOP = 4'd1,
      EV_IR_STOP     = 4'd2,
      EV_FAULT_STOP  = 4'd3,
      EV_START_UP    = 4'd4,
      EV_START_DOWN  = 4'd5,
      EV_REACHED_UP  = 4'd6,
      EV_REACHED_DN  = 4'd7,
      EV_TIMEOUT     = 4'd8,
      EV_EMERGENCY   = 4'd9,
      EV_RESET       = 4'd10
   } event_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]   up_position;
      logic [SAMPLE_W-1:0]   down_position;
      logic [DIST_W-1:0]     object_limit;
      logic [PRESSURE_W-1:0] pressure_limit;
      logic [TIMEOUT_W-1:0]  move_timeout_ms;
      logic [SAMPLE_W-1:0]   start_band;
      logic [SAMPLE_W-1:0]   stop_band;
      logic [DUTY_W-1:0]     motor_duty;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      up_position:     10'd800,
      down_position:   10'd200,
      object_limit:    9'd20,
      pressure_limit:  10'd500,
      move_timeout_ms: 16'd15000,
      start_band:      10'd20,
      stop_band:       10'd10,
      motor_duty:      8'd150
   };

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic                  sensor_update;
      logic [SAMPLE_W-1:0]   position_sample;
      logic [PRESSURE_W-1:0] pressure_sample;
      logic [DIST_W-1:0]     distance_cm;
      logic                  ir_blocked;
      logic                  up_pressed;
      logic                  down_pressed;
      logic [NOW_W-1:0]      now_ms;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]   state_code;
      logic [DRIVE_W-1:0]  drive;
      logic                pump_on;
      logic                valve_open;
      logic [DUTY_W-1:0]   duty_out;
      logic                manual_active;
      logic [SAMPLE_W-1:0] target_out;
      logic                fault_latched;
      logic [EVENT_W-1:0]  event_res;
   } rsp_type;

   function automatic logic [CODE_W-1:0] state_code_f(input state_type s);
      logic [CODE_W-1:0] code;
      case (s)
         ST_IDLE:     code = CODE_IDLE;
         ST_LIFTING:  code = CODE_LIFTING;
         ST_LOWERING: code = CODE_LOWERING;
         ST_UP:       code = CODE_UP;
         ST_DOWN:     code = CODE_DOWN;
         ST_ERROR:    code = CODE_ERROR;
         default:     code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/bridge_lift_sequencer.sv
// ----------------------------------------------------------------------------
// bridge_lift_sequencer
// Control sequencer for a hydraulic lifting bridge, one request per cycle while results are taken.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per transfer (control step, emergency stop or
//            clear after error), kind and sample flag on req_tuser.
//   rsp_*  : exactly one result per request, in request order.
//   csr_*  : register writes, always ready; write only while no request
//            is outstanding.
// Timing: an accepted request sits in the input register, where the state
//   update and result are computed combinationally; the result then lands
//   in the output register, which drives rsp_tvalid. Throughput is one
//   request per cycle while rsp_tready stays high, set by the single-pass
//   state update loop in the core.
// Reset: all sequencer state and registers return to their defaults
//   (idle, target at the lowered position); both channels come up empty.
// Stall: while rsp_tready is low the output register holds its result;
//   one more request is taken into the input register, then req_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module bridge_lift_sequencer
   import blseq_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int TIME_BITS     = TIME_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // position_sample, pressure_sample, distance_cm, ir_blocked,
   // up_pressed, down_pressed, now_ms
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // op, sensor_update
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // state_code, drive, pump_on, valve_open, duty_out, manual_active,
   // target_out, fault_latched, event_res, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_bus;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_core;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_take, fire;

   assign csr_ready = 1'b1;

   blseq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   always_comb begin
      req_bus.op              = req_tuser[1:0];
      req_bus.sensor_update   = req_tuser[2];
      req_bus.position_sample = req_tdata[9:0];
      req_bus.pressure_sample = req_tdata[19:10];
      req_bus.distance_cm     = req_tdata[28:20];
      req_bus.ir_blocked      = req_tdata[29];
      req_bus.up_pressed      = req_tdata[30];
      req_bus.down_pressed    = req_tdata[31];
      req_bus.now_ms          = req_tdata[63:32];
   end

   // request in the input register moves on when the output slot is free or its result is being taken
   assign fire       = req_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~req_valid_ff | fire;
   assign req_take   = req_tvalid & req_tready;

   assign req_valid_in = req_take | (req_valid_ff & ~fire);
   assign req_in       = req_take ? req_bus : req_ff;
   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_tready);
   assign rsp_in       = fire ? rsp_core : rsp_ff;

   blseq_core #(
      .POSITION_BITS (POSITION_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (fire),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_core)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.event_res, rsp_ff.fault_latched, rsp_ff.target_out,
                        rsp_ff.manual_active, rsp_ff.duty_out, rsp_ff.valve_open,
                        rsp_ff.pump_on, rsp_ff.drive, rsp_ff.state_code};

endmodule

FILE: hw/rtl/blseq_csr.sv
// ----------------------------------------------------------------------------
// blseq_csr
// Configuration register file: targets, limits, bands and motor duty.
// ----------------------------------------------------------------------------
module blseq_csr
   import blseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_UP_POSITION:    cfg_in.up_position     = wr_data[SAMPLE_W-1:0];
            REG_DOWN_POSITION:  cfg_in.down_position   = wr_data[SAMPLE_W-1:0];
            REG_OBJECT_LIMIT:   cfg_in.object_limit    = wr_data[DIST_W-1:0];
            REG_PRESSURE_LIMIT: cfg_in.pressure_limit  = wr_data[PRESSURE_W-1:0];
            REG_MOVE_TIMEOUT:   cfg_in.move_timeout_ms = wr_data[TIMEOUT_W-1:0];
            REG_START_BAND:     cfg_in.start_band      = wr_data[SAMPLE_W-1:0];
            REG_STOP_BAND:      cfg_in.stop_band       = wr_data[SAMPLE_W-1:0];
            REG_MOTOR_DUTY:     cfg_in.motor_duty      = wr_data[DUTY_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/blseq_core.sv
// ----------------------------------------------------------------------------
// blseq_core
// Sequencer state and the single-pass next-state / result logic.
// ----------------------------------------------------------------------------
module blseq_core
   import blseq_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int TIME_BITS     = TIME_BITS_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam int PW = POSITION_BITS;
   localparam int TW = TIME_BITS;
   // signed compare width: room for target plus band without overflow
   localparam int CW = ((PW > SAMPLE_W) ? PW : SAMPLE_W) + 2;

   state_type     state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] tgt_ff, tgt_in;
   logic          manual_ff, manual_in;
   logic          fault_ff, fault_in;
   logic [TW-1:0] start_ff, start_in;
   event_type     event_sel;

   logic [PW-1:0] sample_pos, up_pos, down_pos;
   logic [PW-1:0] step_pos, step_tgt;
   logic          step_fault, step_manual;
   logic [TW-1:0] now_t, elapsed;
   logic          timed_out, obj_stop;
   logic signed [CW-1:0] pos_s, tgt_s, diff_s, abs_s, start_band_s, stop_band_s;
   logic          far_off, raise_dir, up_reached, down_reached, moving;

   assign sample_pos = PW'(req.position_sample);
   assign up_pos     = PW'(cfg.up_position);
   assign down_pos   = PW'(cfg.down_position);

   // effect of sample and buttons on a control step
   assign step_pos    = req.sensor_update ? sample_pos : pos_ff;
   assign step_fault  = fault_ff |
                        (req.sensor_update & (req.pressure_sample > cfg.pressure_limit));
   assign step_manual = manual_ff | req.up_pressed | req.down_pressed;
   assign step_tgt    = req.down_pressed ? down_pos : (req.up_pressed ? up_pos : tgt_ff);

   assign pos_s        = $signed(CW'(step_pos));
   assign tgt_s        = $signed(CW'(step_tgt));
   assign start_band_s = $signed(CW'(cfg.start_band));
   assign stop_band_s  = $signed(CW'(cfg.stop_band));
   assign diff_s       = pos_s - tgt_s;
   assign abs_s        = (diff_s < 0) ? -diff_s : diff_s;
   assign far_off      = abs_s > start_band_s;
   assign raise_dir    = tgt_s > pos_s;
   assign up_reached   = pos_s >= (tgt_s - stop_band_s);
   assign down_reached = pos_s <= (tgt_s + stop_band_s);

   assign obj_stop = (step_tgt == down_pos) && (req.distance_cm != '0) &&
                     (req.distance_cm < cfg.object_limit);

   // elapsed time wraps at the time width
   assign now_t     = TW'(req.now_ms);
   assign elapsed   = now_t - start_ff;
   assign timed_out = elapsed > TW'(cfg.move_timeout_ms);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      tgt_in    = tgt_ff;
      manual_in = manual_ff;
      fault_in  = fault_ff;
      start_in  = start_ff;
      event_sel = EV_NONE;
      case (req.op)
         OP_STEP: begin
            pos_in    = step_pos;
            tgt_in    = step_tgt;
            manual_in = step_manual;
            fault_in  = step_fault;
            if ((state_ff == ST_LOWERING) && obj_stop) begin
               state_in  = ST_IDLE;
               event_sel = EV_OBJECT_STOP;
            end else if ((state_ff == ST_LOWERING) && req.ir_blocked) begin
               state_in  = ST_IDLE;
               event_sel = EV_IR_STOP;
            end else if (step_fault) begin
               state_in  = ST_ERROR;
               event_sel = EV_FAULT_STOP;
            end else begin
               case (state_ff)
                  ST_IDLE: begin
                     if (far_off) begin
                        start_in = now_t;
                        if (raise_dir) begin
                           state_in  = ST_LIFTING;
                           event_sel = EV_START_UP;
                        end else begin
                           state_in  = ST_LOWERING;
                           event_sel = EV_START_DOWN;
                        end
                     end
                  end
                  ST_LIFTING: begin
                     if (up_reached) begin
                        state_in  = ST_UP;
                        event_sel = EV_REACHED_UP;
                     end else if (timed_out) begin
                        state_in  = ST_ERROR;
                        event_sel = EV_TIMEOUT;
                     end
                  end
                  ST_LOWERING: begin
                     if (down_reached) begin
                        state_in  = ST_DOWN;
                        event_sel = EV_REACHED_DN;
                     end else if (timed_out) begin
                        state_in  = ST_ERROR;
                        event_sel = EV_TIMEOUT;
                     end
                  end
                  ST_UP, ST_DOWN: begin
                     state_in  = ST_IDLE;
                     manual_in = 1'b0;
                  end
                  default: begin
                     state_in = state_ff;
                  end
               endcase
            end
         end
         OP_ESTOP: begin
            state_in  = ST_ERROR;
            fault_in  = 1'b1;
            event_sel = EV_EMERGENCY;
         end
         OP_CLEAR: begin
            state_in  = ST_IDLE;
            fault_in  = 1'b0;
            manual_in = 1'b0;
            pos_in    = sample_pos;
            event_sel = EV_RESET;
         end
         default: begin
            event_sel = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         tgt_ff    <= PW'(CFG_RESET.down_position);
         manual_ff <= 1'b0;
         fault_ff  <= 1'b0;
         start_ff  <= '0;
      end else if (step_en) begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         tgt_ff    <= tgt_in;
         manual_ff <= manual_in;
         fault_ff  <= fault_in;
         start_ff  <= start_in;
      end
   end

   assign moving = (state_in == ST_LIFTING) || (state_in == ST_LOWERING);

   always_comb begin
      rsp.state_code    = state_code_f(state_in);
      rsp.drive         = (state_in == ST_LIFTING)  ? DRIVE_RAISE :
                          (state_in == ST_LOWERING) ? DRIVE_LOWER : DRIVE_STOP;
      rsp.pump_on       = moving;
      rsp.valve_open    = moving;
      rsp.duty_out      = moving ? cfg.motor_duty : '0;
      rsp.manual_active = manual_in;
      rsp.target_out    = SAMPLE_W'(tgt_in);
      rsp.fault_latched = fault_in;
      rsp.event_res     = event_sel;
   end

endmodule

FILE: tb/bridge_lift_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_lift_checker
// Watches the request, result and register channels of the bridge lift
// sequencer, keeps its own copy of the sequencer state and registers, and
// compares every result word field by field against the predicted status.
// ----------------------------------------------------------------------------
module bridge_lift_checker
   import blseq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     status_count,
   output int                     pending_count
);

   localparam int REPORT_CAP = 200;

   cfg_type             regs;
   logic [CODE_W-1:0]   mode;
   logic [SAMPLE_W-1:0] held_position;
   logic [SAMPLE_W-1:0] target;
   logic                manual;
   logic                fault;
   logic [NOW_W-1:0]    move_start;

   rsp_type status_q[$];
   int      mismatches;
   int      received;

   task automatic apply_request(input logic [REQ_TDATA_W-1:0] d,
                                input logic [REQ_TUSER_W-1:0] u,
                                output rsp_type r);
      logic [SAMPLE_W-1:0]   sample_pos;
      logic [PRESSURE_W-1:0] sample_pres;
      logic [DIST_W-1:0]     range_cm;
      logic [NOW_W-1:0]      now, elapsed;
      logic                  ir, btn_up, btn_down, moving;
      int                    pos, tgt, gap;
      event_type             ev;
      {now, btn_down, btn_up, ir, range_cm, sample_pres, sample_pos} = d;
      ev = EV_NONE;
      case (u[OP_W-1:0])
         OP_STEP: begin
            if (u[OP_W]) begin
               held_position = sample_pos;
               if (sample_pres > regs.pressure_limit)
                  fault = 1'b1;
            end
            // down button overrides up
            if (btn_up) begin
               manual = 1'b1;
               target = regs.up_position;
            end
            if (btn_down) begin
               manual = 1'b1;
               target = regs.down_position;
            end
            pos     = int'(held_position);
            tgt     = int'(target);
            elapsed = now - move_start;
            if (mode == CODE_LOWERING && target == regs.down_position &&
                range_cm != '0 && range_cm < regs.object_limit) begin
               mode = CODE_IDLE;
               ev   = EV_OBJECT_STOP;
            end else if (mode == CODE_LOWERING && ir) begin
               mode = CODE_IDLE;
               ev   = EV_IR_STOP;
            end else if (fault) begin
               mode = CODE_ERROR;
               ev   = EV_FAULT_STOP;
            end else begin
               case (mode)
                  CODE_IDLE: begin
                     gap = pos - tgt;
                     if (gap < 0)
                        gap = -gap;
                     if (gap > int'(regs.start_band)) begin
                        move_start = now;
                        if (tgt > pos) begin
                           mode = CODE_LIFTING;
                           ev   = EV_START_UP;
                        end else begin
                           mode = CODE_LOWERING;
                           ev   = EV_START_DOWN;
                        end
                     end
                  end
                  CODE_LIFTING: begin
                     // signed compare: a negative threshold always passes
                     if (pos >= tgt - int'(regs.stop_band)) begin
                        mode = CODE_UP;
                        ev   = EV_REACHED_UP;
                     end else if (elapsed > NOW_W'(regs.move_timeout_ms)) begin
                        mode = CODE_ERROR;
                        ev   = EV_TIMEOUT;
                     end
                  end
                  CODE_LOWERING: begin
                     if (pos <= tgt + int'(regs.stop_band)) begin
                        mode = CODE_DOWN;
                        ev   = EV_REACHED_DN;
                     end else if (elapsed > NOW_W'(regs.move_timeout_ms)) begin
                        mode = CODE_ERROR;
                        ev   = EV_TIMEOUT;
                     end
                  end
                  CODE_UP, CODE_DOWN: begin
                     mode   = CODE_IDLE;
                     manual = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         OP_ESTOP: begin
            mode  = CODE_ERROR;
            fault = 1'b1;
            ev    = EV_EMERGENCY;
         end
         OP_CLEAR: begin
            fault         = 1'b0;
            mode          = CODE_IDLE;
            manual        = 1'b0;
            held_position = sample_pos;
            ev            = EV_RESET;
         end
         default: ;
      endcase

      moving          = (mode == CODE_LIFTING) || (mode == CODE_LOWERING);
      r.state_code    = mode;
      r.drive         = (mode == CODE_LIFTING)  ? DRIVE_RAISE :
                        (mode == CODE_LOWERING) ? DRIVE_LOWER : DRIVE_STOP;
      r.pump_on       = moving;
      r.valve_open    = moving;
      r.duty_out      = moving ? regs.motor_duty : '0;
      r.manual_active = manual;
      r.target_out    = target;
      r.fault_latched = fault;
      r.event_res     = ev;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         if (mismatches < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want, got;
      logic    pad;
      if (reset) begin
         regs          = CFG_RESET;
         mode          = CODE_IDLE;
         held_position = '0;
         target        = CFG_RESET.down_position;
         manual        = 1'b0;
         fault         = 1'b0;
         move_start    = '0;
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_UP_POSITION:    regs.up_position     = csr_wdata[SAMPLE_W-1:0];
               REG_DOWN_POSITION:  regs.down_position   = csr_wdata[SAMPLE_W-1:0];
               REG_OBJECT_LIMIT:   regs.object_limit    = csr_wdata[DIST_W-1:0];
               REG_PRESSURE_LIMIT: regs.pressure_limit  = csr_wdata[PRESSURE_W-1:0];
               REG_MOVE_TIMEOUT:   regs.move_timeout_ms = csr_wdata[TIMEOUT_W-1:0];
               REG_START_BAND:     regs.start_band      = csr_wdata[SAMPLE_W-1:0];
               REG_STOP_BAND:      regs.stop_band       = csr_wdata[SAMPLE_W-1:0];
               REG_MOTOR_DUTY:     regs.motor_duty      = csr_wdata[DUTY_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            received++;
            {pad, got.event_res, got.fault_latched, got.target_out, got.manual_active,
             got.duty_out, got.valve_open, got.pump_on, got.drive, got.state_code} = rsp_tdata;
            if (status_q.size() == 0) begin
               if (mismatches < REPORT_CAP)
                  $display("%0t: unexpected result, expected none, actual %h",
                           $time, rsp_tdata);
               mismatches++;
            end else begin
               want = status_q.pop_front();
               compare_field("state_code", want.state_code, got.state_code);
               compare_field("drive", want.drive, got.drive);
               compare_field("pump_on", want.pump_on, got.pump_on);
               compare_field("valve_open", want.valve_open, got.valve_open);
               compare_field("duty_out", want.duty_out, got.duty_out);
               compare_field("manual_active", want.manual_active, got.manual_active);
               compare_field("target_out", want.target_out, got.target_out);
               compare_field("fault_latched", want.fault_latched, got.fault_latched);
               compare_field("event_res", want.event_res, got.event_res);
               compare_field("pad bit", 0, pad);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tdata, req_tuser, want);
            status_q.push_back(want);
         end
      end
      fail_count    <= mismatches;
      status_count  <= received;
      pending_count <= status_q.size();
   end

endmodule

FILE: tb/bridge_lift_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bridge_lift_sequencer_tb
// Drives the bridge lift sequencer with a directed run through every state,
// event and request kind, then random requests of all kinds under several
// register settings with random gaps on the request side and random result stalls.
// ----------------------------------------------------------------------------
module bridge_lift_sequencer_tb;
   import blseq_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // position_sample, pressure_sample, distance_cm, ir_blocked,
   // up_pressed, down_pressed, now_ms
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // op, sensor_update
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   // state_code, drive, pump_on, valve_open, duty_out, manual_active,
   // target_out, fault_latched, event_res, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count, status_count, pending_count;
   int sent;
   bit req_calm, rsp_calm;

   cfg_type          plan;
   logic [NOW_W-1:0] clock_ms;

   bridge_lift_sequencer DUT (.*);

   bridge_lift_checker status_check (.*);

   initial forever #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int random_gap(input bit calm);
      int r;
      r = $urandom_range(99, 0);
      if (calm || r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // result-side back pressure
   initial begin
      int stall;
      forever begin
         if ($urandom_range(99, 0) < 3)
            rsp_calm = !rsp_calm;
         stall = random_gap(rsp_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic fresh,
                               input logic [SAMPLE_W-1:0] pos,
                               input logic [PRESSURE_W-1:0] pres,
                               input logic [DIST_W-1:0] range_cm,
                               input logic ir, input logic btn_up, input logic btn_down,
                               input logic [NOW_W-1:0] now);
      int gap;
      req_tdata  <= {now, btn_down, btn_up, ir, range_cm, pres, pos};
      req_tuser  <= {fresh, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      if ($urandom_range(99, 0) < 3)
         req_calm = !req_calm;
      gap = random_gap(req_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_count != sent) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      logic [CSR_INDEX_W-1:0] idx [8];
      logic [CSR_DATA_W-1:0]  vals [8];
      idx = '{REG_UP_POSITION, REG_DOWN_POSITION, REG_OBJECT_LIMIT, REG_PRESSURE_LIMIT,
              REG_MOVE_TIMEOUT, REG_START_BAND, REG_STOP_BAND, REG_MOTOR_DUTY};
      // junk above each register's width must be dropped
      foreach (vals[i])
         vals[i] = CSR_DATA_W'($urandom);
      vals[0][SAMPLE_W-1:0]   = c.up_position;
      vals[1][SAMPLE_W-1:0]   = c.down_position;
      vals[2][DIST_W-1:0]     = c.object_limit;
      vals[3][PRESSURE_W-1:0] = c.pressure_limit;
      vals[4]                 = c.move_timeout_ms;
      vals[5][SAMPLE_W-1:0]   = c.start_band;
      vals[6][SAMPLE_W-1:0]   = c.stop_band;
      vals[7][DUTY_W-1:0]     = c.motor_duty;
      // unmapped index, must be ignored
      csr_index <= CSR_INDEX_W'($urandom_range({CSR_INDEX_W{1'b1}}, REG_MOTOR_DUTY + 1));
      csr_wdata <= CSR_DATA_W'($urandom);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      foreach (idx[i]) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      plan = c;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.up_position     = SAMPLE_W'($urandom_range(1023, 600));
      c.down_position   = SAMPLE_W'($urandom_range(400, 0));
      c.object_limit    = DIST_W'($urandom_range(60, 1));
      c.pressure_limit  = PRESSURE_W'($urandom_range(1023, 300));
      c.move_timeout_ms = TIMEOUT_W'($urandom_range(3000, 0));
      c.start_band      = SAMPLE_W'($urandom_range(60, 0));
      c.stop_band       = SAMPLE_W'($urandom_range(40, 0));
      c.motor_duty      = DUTY_W'($urandom);
      return c;
   endfunction

   task automatic random_request();
      logic [OP_W-1:0]       op;
      logic [SAMPLE_W-1:0]   base;
      logic [PRESSURE_W-1:0] pres;
      logic [DIST_W-1:0]     range_cm;
      int                    r, p;
      r = $urandom_range(99, 0);
      if (r < 86)      op = OP_STEP;
      else if (r < 89) op = OP_ESTOP;
      else if (r < 97) op = OP_CLEAR;
      else             op = OP_SPARE;

      // positions mostly near one of the targets so moves can finish
      if ($urandom_range(99, 0) < 35) begin
         p = $urandom_range(1023, 0);
      end else begin
         base = $urandom_range(1, 0) ? plan.up_position : plan.down_position;
         p = base + int'($urandom_range(60, 0)) - 30;
         if (p < 0)
            p = 0;
         if (p > 1023)
            p = 1023;
      end

      if ($urandom_range(99, 0) < 4)
         pres = PRESSURE_W'($urandom_range(1023, plan.pressure_limit));
      else
         pres = PRESSURE_W'($urandom_range(plan.pressure_limit, 0));

      r = $urandom_range(99, 0);
      if (r < 50)      range_cm = '0;
      else if (r < 70) range_cm = DIST_W'($urandom_range(plan.object_limit, 1));
      else             range_cm = DIST_W'($urandom);

      r = $urandom_range(99, 0);
      if (r < 2)       clock_ms = $urandom;
      else if (r < 7)  clock_ms += $urandom_range(70000, 0);
      else             clock_ms += $urandom_range(500, 0);

      send_request(op, $urandom_range(99, 0) < 75, SAMPLE_W'(p), pres, range_cm,
                   $urandom_range(99, 0) < 6, $urandom_range(99, 0) < 8,
                   $urandom_range(99, 0) < 8, clock_ms);
   endtask

   initial begin
      cfg_type c;
      plan     = CFG_RESET;
      clock_ms = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed run on reset registers
      send_request(OP_STEP, 1, 0, 0, 0, 0, 0, 0, 1000);        // start up
      send_request(OP_STEP, 1, 195, 0, 0, 0, 0, 0, 1100);      // reached up
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 1200);        // back to idle
      send_request(OP_STEP, 1, 500, 100, 0, 0, 1, 0, 2000);    // manual up
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 17000);       // elapsed at limit
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 17001);       // timeout
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 17002);       // error holds
      send_request(OP_CLEAR, 0, 1023, 0, 0, 0, 0, 0, 17003);
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFF0);
      send_request(OP_STEP, 0, 0, 0, 19, 0, 0, 0, 32'h0000_0010); // object stop
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
      send_request(OP_STEP, 0, 0, 0, 20, 1, 0, 0, 5);            // IR stop
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
      send_request(OP_STEP, 1, 1023, 0, 511, 0, 0, 0, 32'h0000_0100); // wrapped time
      send_request(OP_STEP, 1, 210, 0, 0, 0, 0, 0, 32'h0000_0200);    // reached down
      send_request(OP_STEP, 0, 0, 0, 0, 0, 1, 1, 32'h0000_0300);      // both buttons
      send_request(OP_STEP, 1, 210, 500, 0, 0, 0, 0, 32'h0000_0400);
      send_request(OP_STEP, 1, 210, 501, 0, 0, 0, 0, 32'h0000_0500);  // fault
      send_request(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0600);
      send_request(OP_ESTOP, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0700);
      send_request(OP_SPARE, 1, 1023, 1023, 511, 1, 1, 1, 32'hFFFF_FFFF);
      send_request(OP_CLEAR, 0, 1023, 0, 0, 0, 0, 0, 32'h0000_0800);
      send_request(OP_STEP, 0, 0, 0, 0, 0, 1, 0, 32'h0000_0900);      // lower to up target
      send_request(OP_STEP, 0, 0, 0, 1, 0, 0, 0, 32'h0000_0A00);      // no object stop here
      send_request(OP_STEP, 0, 0, 0, 0, 1, 0, 0, 32'h0000_0B00);      // IR stop
      send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0C00);
      clock_ms = 32'h0000_0C00;
      drain();

      program_regs(CFG_RESET);
      repeat (120) random_request();
      drain();

      c = '{up_position: 10'd1023, down_position: 10'd0, object_limit: 9'd511,
            pressure_limit: 10'd1023, move_timeout_ms: 16'd0, start_band: 10'd0,
            stop_band: 10'd0, motor_duty: 8'd255};
      program_regs(c);
      repeat (90) random_request();
      drain();

      c = '{up_position: 10'd0, down_position: 10'd1023, object_limit: 9'd0,
            pressure_limit: 10'd0, move_timeout_ms: 16'hFFFF, start_band: 10'd1023,
            stop_band: 10'd1023, motor_duty: 8'd0};
      program_regs(c);
      repeat (60) random_request();
      drain();

      repeat (2) begin
         program_regs(random_cfg());
         repeat (140) random_request();
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
